[rtl/core/bsrs_pkg.sv]
// Package for the bus shift register sequencer.
// Holds item and configuration types, register indexes and sizing constants.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bsrs_pkg;

	localparam int STEP_COUNT     = 16;
	localparam int RING_STEPS     = 8;
	localparam int BUS_COUNT      = 3;
	localparam int PITCH_BITS     = 8;
	localparam int LANE_BITS      = (PITCH_BITS < 8) ? PITCH_BITS : 8;
	localparam logic [7:0] LANE_MASK = 8'((1 << LANE_BITS) - 1);
	localparam int CV_BITS        = 11;
	localparam int DIFF_BITS      = 12;
	localparam int WORK_BITS      = 13;
	localparam int PULSE_BITS     = 16;
	localparam int THRESH_BITS    = 17;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 64;

	// Bus select value that leaves a step on no bus.
	localparam logic [1:0] BUS_NONE = 2'd3;

	// switch_flags bit positions
	localparam int FLAG_SPLIT   = 0;
	localparam int FLAG_FILL    = 1;
	localparam int FLAG_INVERT  = 2;
	localparam int FLAG_AND     = 3;
	localparam int FLAG_RELOAD  = 4;
	localparam int FLAG_MERGE_0 = 5;

	typedef enum logic [1:0] {
		OP_RISE = 2'd0,
		OP_FALL = 2'd1,
		OP_LOAD = 2'd2,
		OP_TICK = 2'd3
	} op_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_LOAD_PATTERN     = 3'd0,
		REG_BUS_ASSIGN       = 3'd1,
		REG_SWITCH_FLAGS     = 3'd2,
		REG_PITCH_A_STEPS    = 3'd3,
		REG_PITCH_B_STEPS    = 3'd4,
		REG_RANDOM_THRESHOLD = 3'd5,
		REG_PULSE_TICKS      = 3'd6,
		REG_CV_LIMIT         = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] random_sample;
	} evt_item_t;

	typedef struct packed {
		logic [BUS_COUNT-1:0]        gate_bits;
		logic [BUS_COUNT-1:0]        trigger_bits;
		logic [CV_BITS-1:0]          cv_a;
		logic [CV_BITS-1:0]          cv_b;
		logic [CV_BITS-1:0]          cv_sum;
		logic signed [DIFF_BITS-1:0] cv_diff;
		logic [STEP_COUNT-1:0]       pattern_now;
	} res_item_t;

	typedef struct packed {
		logic [STEP_COUNT-1:0]   load_pattern;
		logic [2*STEP_COUNT-1:0] bus_assign;
		logic [7:0]              switch_flags;
		logic [63:0]             pitch_a_steps;
		logic [63:0]             pitch_b_steps;
		logic [THRESH_BITS-1:0]  random_threshold;
		logic [PULSE_BITS-1:0]   pulse_ticks;
		logic [CV_BITS-1:0]      cv_limit;
	} cfg_regs_t;

endpackage

`default_nettype wire

[rtl/core/bsrs_cfg.sv]
// Configuration register file of the bus shift register sequencer.
// Depends on bsrs_pkg for the register indexes and the cfg_regs_t bundle.
`default_nettype none

module bsrs_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [bsrs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [bsrs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output bsrs_pkg::cfg_regs_t                      regs
);
	import bsrs_pkg::*;

	cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.load_pattern     <= '0;
			regs_q.bus_assign       <= '0;
			regs_q.switch_flags     <= '0;
			regs_q.pitch_a_steps    <= '0;
			regs_q.pitch_b_steps    <= '0;
			regs_q.random_threshold <= THRESH_BITS'(32768);
			regs_q.pulse_ticks      <= PULSE_BITS'(48);
			regs_q.cv_limit         <= CV_BITS'(2047);
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_LOAD_PATTERN:     regs_q.load_pattern     <= cfg_data[STEP_COUNT-1:0];
				REG_BUS_ASSIGN:       regs_q.bus_assign       <= cfg_data[2*STEP_COUNT-1:0];
				REG_SWITCH_FLAGS:     regs_q.switch_flags     <= cfg_data[7:0];
				REG_PITCH_A_STEPS:    regs_q.pitch_a_steps    <= cfg_data[63:0];
				REG_PITCH_B_STEPS:    regs_q.pitch_b_steps    <= cfg_data[63:0];
				REG_RANDOM_THRESHOLD: regs_q.random_threshold <= cfg_data[THRESH_BITS-1:0];
				REG_PULSE_TICKS:      regs_q.pulse_ticks      <= cfg_data[PULSE_BITS-1:0];
				REG_CV_LIMIT:         regs_q.cv_limit         <= cfg_data[CV_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/bsrs_core.sv]
// Sequencer state and single-pass event logic: rotate, bus decode, reload,
// trigger pulses, pitch sums and clamps. Depends on bsrs_pkg.
`default_nettype none

module bsrs_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire bsrs_pkg::evt_item_t item,
	input  wire bsrs_pkg::cfg_regs_t cfg,
	output bsrs_pkg::res_item_t      result
);
	import bsrs_pkg::*;

	logic [STEP_COUNT-1:0]       step_q;
	logic [BUS_COUNT-1:0]        bus_q;
	logic [BUS_COUNT-1:0]        gate_q;
	logic [BUS_COUNT-1:0]        trig_q;
	logic [PULSE_BITS-1:0]       remain_q [BUS_COUNT];
	logic [CV_BITS-1:0]          cva_q;
	logic [CV_BITS-1:0]          cvb_q;
	logic [CV_BITS-1:0]          cvs_q;
	logic signed [DIFF_BITS-1:0] cvd_q;

	logic [STEP_COUNT-1:0]       step_d;
	logic [BUS_COUNT-1:0]        bus_d;
	logic [BUS_COUNT-1:0]        gate_d;
	logic [BUS_COUNT-1:0]        trig_d;
	logic [PULSE_BITS-1:0]       remain_d [BUS_COUNT];
	logic [CV_BITS-1:0]          cva_d;
	logic [CV_BITS-1:0]          cvb_d;
	logic [CV_BITS-1:0]          cvs_d;
	logic signed [DIFF_BITS-1:0] cvd_d;

	logic                        rnd_bit;
	logic                        fill_a;
	logic [STEP_COUNT-1:0]       rot;
	logic [BUS_COUNT-1:0]        lv;
	logic [BUS_COUNT-1:0]        bus_new;
	logic                        reload;
	logic [STEP_COUNT-1:0]       rise_steps;
	logic signed [WORK_BITS-1:0] sum_a;
	logic signed [WORK_BITS-1:0] sum_b;
	logic signed [WORK_BITS-1:0] sum_s;
	logic signed [WORK_BITS-1:0] sum_d;
	logic signed [WORK_BITS-1:0] lim;
	logic [BUS_COUNT-1:0]        rise_trig;
	logic [PULSE_BITS-1:0]       rise_remain [BUS_COUNT];
	logic [BUS_COUNT-1:0]        tick_trig;
	logic [PULSE_BITS-1:0]       tick_remain [BUS_COUNT];

	// Rotate the ring(s); the bit entering ring A may be random.
	always_comb begin
		rnd_bit = ({1'b0, item.random_sample} <= cfg.random_threshold);
		fill_a  = cfg.switch_flags[FLAG_FILL] ? rnd_bit : step_q[RING_STEPS-1];
		if (!cfg.switch_flags[FLAG_SPLIT]) begin
			rot = {step_q[STEP_COUNT-2:0],
				cfg.switch_flags[FLAG_FILL] ? rnd_bit : step_q[STEP_COUNT-1]};
		end else begin
			rot = {step_q[STEP_COUNT-2:RING_STEPS],
				step_q[STEP_COUNT-1] ^ cfg.switch_flags[FLAG_INVERT],
				step_q[RING_STEPS-2:0], fill_a};
		end
	end

	// Decode buses from set steps, then apply the bus 1 logic gate.
	always_comb begin
		lv = '0;
		for (int b = 0; b < BUS_COUNT; b++) begin
			for (int k = 0; k < STEP_COUNT; k++) begin
				if (rot[k] && (cfg.bus_assign[2*k +: 2] == 2'(b))) begin
					lv[b] = 1'b1;
				end
			end
		end
		bus_new    = lv;
		bus_new[1] = cfg.switch_flags[FLAG_AND] ? (lv[0] & lv[2]) : (lv[1] & ~(lv[0] | lv[2]));
		reload     = cfg.switch_flags[FLAG_RELOAD] && !bus_q[0] && lv[0];
		rise_steps = reload ? cfg.load_pattern : rot;
	end

	// Pitch sums of the set steps of each ring, then clamp.
	always_comb begin
		sum_a = '0;
		sum_b = '0;
		for (int k = 0; k < RING_STEPS; k++) begin
			if (rise_steps[k]) begin
				sum_a = sum_a + WORK_BITS'(cfg.pitch_a_steps[8*k +: 8] & LANE_MASK);
			end
			if (rise_steps[k+RING_STEPS]) begin
				sum_b = sum_b + WORK_BITS'(cfg.pitch_b_steps[8*k +: 8] & LANE_MASK);
			end
		end
		lim   = WORK_BITS'(cfg.cv_limit);
		sum_s = sum_a + sum_b;
		sum_d = sum_a - sum_b;
		cva_d = CV_BITS'((sum_a > lim) ? lim : sum_a);
		cvb_d = CV_BITS'((sum_b > lim) ? lim : sum_b);
		cvs_d = CV_BITS'((sum_s > lim) ? lim : sum_s);
		if (sum_d > lim) begin
			cvd_d = DIFF_BITS'(lim);
		end else if (sum_d < -lim) begin
			cvd_d = DIFF_BITS'(-lim);
		end else begin
			cvd_d = DIFF_BITS'(sum_d);
		end
	end

	// Trigger start on rise and countdown on tick.
	always_comb begin
		rise_trig = trig_q | bus_new;
		tick_trig = trig_q;
		for (int k = 0; k < BUS_COUNT; k++) begin
			rise_remain[k] = remain_q[k];
			if (bus_new[k] && (cfg.pulse_ticks > remain_q[k])) begin
				rise_remain[k] = cfg.pulse_ticks;
			end
			tick_remain[k] = remain_q[k];
			if (trig_q[k]) begin
				if (remain_q[k] != '0) begin
					tick_remain[k] = remain_q[k] - PULSE_BITS'(1);
				end else begin
					tick_trig[k] = 1'b0;
				end
			end
		end
	end

	// Select the next state by event kind; the sums hold except on rise.
	always_comb begin
		step_d   = step_q;
		bus_d    = bus_q;
		gate_d   = gate_q;
		trig_d   = trig_q;
		remain_d = remain_q;
		unique case (op_t'(item.operation))
			OP_RISE: begin
				step_d   = rise_steps;
				bus_d    = bus_new;
				gate_d   = bus_new;
				trig_d   = rise_trig;
				remain_d = rise_remain;
			end
			OP_FALL: begin
				gate_d = gate_q & bus_q & cfg.switch_flags[FLAG_MERGE_0 +: BUS_COUNT];
			end
			OP_LOAD: begin
				step_d = cfg.load_pattern;
			end
			OP_TICK: begin
				trig_d   = tick_trig;
				remain_d = tick_remain;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			bus_q  <= '0;
			gate_q <= '0;
			trig_q <= '0;
			cva_q  <= '0;
			cvb_q  <= '0;
			cvs_q  <= '0;
			cvd_q  <= '0;
			for (int k = 0; k < BUS_COUNT; k++) begin
				remain_q[k] <= '0;
			end
		end else if (fire) begin
			step_q   <= step_d;
			bus_q    <= bus_d;
			gate_q   <= gate_d;
			trig_q   <= trig_d;
			remain_q <= remain_d;
			if (op_t'(item.operation) == OP_RISE) begin
				cva_q <= cva_d;
				cvb_q <= cvb_d;
				cvs_q <= cvs_d;
				cvd_q <= cvd_d;
			end
		end
	end

	// Result of the item being processed, from the state it leaves behind.
	always_comb begin
		result.gate_bits    = gate_d;
		result.trigger_bits = trig_d;
		result.pattern_now  = step_d;
		if (op_t'(item.operation) == OP_RISE) begin
			result.cv_a    = cva_d;
			result.cv_b    = cvb_d;
			result.cv_sum  = cvs_d;
			result.cv_diff = cvd_d;
		end else begin
			result.cv_a    = cva_q;
			result.cv_b    = cvb_q;
			result.cv_sum  = cvs_q;
			result.cv_diff = cvd_q;
		end
	end

endmodule

`default_nettype wire

[rtl/core/bus_shift_register_sequencer_top.sv]
// Top level of the bus shift register sequencer: input register, event core,
// result register and configuration registers. Depends on bsrs_pkg,
// bsrs_cfg and bsrs_core.
//
//   channel  handshake             payload        direction
//   evt      evt_valid/evt_stall   evt_item_t     in  (one event per item)
//   res      res_valid/res_stall   res_item_t     out (one result per event)
//   cfg      cfg_valid/cfg_ready   index + data   in  (register writes)
//
// An accepted event item sits in the input register while the event logic
// works on it, and fire loads its result into the result register, which
// drives res. One item can be accepted every cycle while evt_stall is low.
// A stall on res holds the result register and, once the input register is
// also full, raises evt_stall. arst_n clears all valid flags and sequencer
// state and loads register reset values.
`default_nettype none

module bus_shift_register_sequencer_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                evt_valid,
	output logic                                     evt_stall,
	input  wire bsrs_pkg::evt_item_t                 evt_item,
	output logic                                     res_valid,
	input  wire logic                                res_stall,
	output bsrs_pkg::res_item_t                      res_item,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [bsrs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [bsrs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import bsrs_pkg::*;

	cfg_regs_t  cfg;
	evt_item_t  item_s1;
	logic       valid_s1;
	res_item_t  result;
	res_item_t  res_item_q;
	logic       res_valid_q;
	logic       adv_ok;
	logic       fire;
	logic       accept;

	// The result register frees up when empty or when its item is taken.
	assign adv_ok    = !res_valid_q || !res_stall;
	assign fire      = valid_s1 && adv_ok;
	assign evt_stall = valid_s1 && !adv_ok;
	assign accept    = evt_valid && !evt_stall;
	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	bsrs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (cfg)
	);

	bsrs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Input register: load on accept, drop once the item fires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= evt_item;
		end
	end

	// Result register: hold while stalled, advance on fire.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_item_q <= result;
		end
	end

endmodule

`default_nettype wire
